@@ sv/srev_pkg.sv @@
package srev_pkg;

    localparam int SAMPLE_RATE_HZ_DEF = 48000;
    localparam int MAX_PREDELAY_DEF   = 9600;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int PD_W     = 14;
    localparam int ADDR_W   = 6;
    localparam int DATA_W   = 64;

    localparam logic [2:0] REG_GAINS_LOW  = 3'd0;
    localparam logic [2:0] REG_GAINS_HIGH = 3'd1;
    localparam logic [2:0] REG_DAMPING    = 3'd2;
    localparam logic [2:0] REG_WET        = 3'd3;
    localparam logic [2:0] REG_PREDELAY   = 3'd4;

    localparam logic [15:0] DAMPING_RST = 16'd32768;
    localparam logic [15:0] WET_RST     = 16'd19661;
    localparam logic [13:0] PREDELAY_RST = 14'd960;

    function automatic int dlen(input int rate, input int ms);
        return (rate * ms) / 1000;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        if (v > 40'sd32767)
            return 16'sh7fff;
        else if (v < -40'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PD_RD,
        ST_PD_WAIT,
        ST_AP_RD,
        ST_AP_WAIT,
        ST_AP_CALC,
        ST_CB_RD,
        ST_CB_WAIT,
        ST_CB_MUL1,
        ST_CB_MUL2,
        ST_CB_WR,
        ST_MIX1,
        ST_MIX2,
        ST_MIX3,
        ST_OUT
    } state_t;

endpackage

@@ sv/srev_stream_if.sv @@
interface srev_stream_if;
    import srev_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

@@ sv/srev_regs.sv @@
module srev_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srev_pkg::ADDR_W-1:0]   paddr,
    input  logic [srev_pkg::DATA_W-1:0]   pwdata,
    output logic [srev_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [63:0]                   gains_low,
    output logic [63:0]                   gains_high,
    output logic [15:0]                   damping,
    output logic [15:0]                   wet,
    output logic [13:0]                   predelay
);
    import srev_pkg::*;

    logic [63:0] gl_reg, gh_reg;
    logic [15:0] damp_reg, wet_reg;
    logic [13:0] pd_reg;
    logic        wr;
    logic [2:0]  idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gl_reg   <= '0;
            gh_reg   <= '0;
            damp_reg <= DAMPING_RST;
            wet_reg  <= WET_RST;
            pd_reg   <= PREDELAY_RST;
        end
        else if (wr && paddr[2:0] == 3'd0)
        begin
            unique case (idx)
                REG_GAINS_LOW:  gl_reg <= pwdata;
                REG_GAINS_HIGH: gh_reg <= pwdata;
                REG_DAMPING:    damp_reg <= pwdata[15:0];
                REG_WET:        wet_reg <= pwdata[15:0];
                REG_PREDELAY:   pd_reg <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_GAINS_LOW:  prdata = gl_reg;
            REG_GAINS_HIGH: prdata = gh_reg;
            REG_DAMPING:    prdata = {48'd0, damp_reg};
            REG_WET:        prdata = {48'd0, wet_reg};
            REG_PREDELAY:   prdata = {50'd0, pd_reg};
            default:        prdata = '0;
        endcase
    end

    assign gains_low  = gl_reg;
    assign gains_high = gh_reg;
    assign damping    = damp_reg;
    assign wet        = wet_reg;
    assign predelay   = pd_reg;
endmodule

@@ sv/srev_core.sv @@
module srev_core #(
    parameter int SAMPLE_RATE_HZ = srev_pkg::SAMPLE_RATE_HZ_DEF,
    parameter int MAX_PREDELAY   = srev_pkg::MAX_PREDELAY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    srev_stream_if.sink   in_s,
    srev_stream_if.source out_s,
    input  logic [63:0] gains_low,
    input  logic [63:0] gains_high,
    input  logic [15:0] damping,
    input  logic [15:0] wet,
    input  logic [13:0] predelay
);
    import srev_pkg::*;

    localparam int AL0 = dlen(SAMPLE_RATE_HZ, 5) + 1;
    localparam int AL1 = dlen(SAMPLE_RATE_HZ, 7) + 1;
    localparam int AL2 = dlen(SAMPLE_RATE_HZ, 11) + 1;
    localparam int AL3 = dlen(SAMPLE_RATE_HZ, 13) + 1;
    localparam int AP_DEPTH = AL0 + AL1 + AL2 + AL3;
    localparam int CL0 = dlen(SAMPLE_RATE_HZ, 25) + 1;
    localparam int CL1 = dlen(SAMPLE_RATE_HZ, 27) + 1;
    localparam int CL2 = dlen(SAMPLE_RATE_HZ, 29) + 1;
    localparam int CL3 = dlen(SAMPLE_RATE_HZ, 31) + 1;
    localparam int CL4 = dlen(SAMPLE_RATE_HZ, 37) + 1;
    localparam int CL5 = dlen(SAMPLE_RATE_HZ, 41) + 1;
    localparam int CL6 = dlen(SAMPLE_RATE_HZ, 43) + 1;
    localparam int CL7 = dlen(SAMPLE_RATE_HZ, 47) + 1;
    localparam int CB_DEPTH = CL0 + CL1 + CL2 + CL3 + CL4 + CL5 + CL6 + CL7;
    localparam int PD_DEPTH = MAX_PREDELAY + 1;
    localparam int CB_AW = $clog2(CB_DEPTH);
    localparam int AP_AW = $clog2(AP_DEPTH);
    localparam int PD_AW = $clog2(PD_DEPTH);
    localparam int CLR_N = (CB_DEPTH > PD_DEPTH) ? CB_DEPTH : PD_DEPTH;
    localparam int CLR_W = $clog2(CLR_N + 1);

    logic signed [15:0] cb_mem [CB_DEPTH];
    logic signed [15:0] ap_mem [AP_DEPTH];
    logic signed [15:0] pd_mem [PD_DEPTH];

    state_t state_reg, state_next;

    logic [CLR_W-1:0] clr_reg;
    logic [2:0] k_reg;
    logic [CB_AW-1:0] cpos_reg [8];
    logic [AP_AW-1:0] apos_reg [4];
    logic [PD_AW-1:0] ppos_reg;
    logic signed [15:0] lp_reg [8];
    logic signed [15:0] x_reg, v_reg, rd_reg, y_reg;
    logic signed [39:0] prod_reg, acc_reg;
    logic signed [18:0] sum_reg;

    logic [CB_AW-1:0] cbase, clen;
    logic [AP_AW-1:0] abase, alen;
    logic [15:0] gain;
    logic [PD_AW-1:0] pd_d, pd_rd;
    logic [CB_AW-1:0] crd;
    logic [AP_AW-1:0] ard;
    logic signed [16:0] diff;
    logic signed [39:0] lp_new, ap_x, ap_y;
    logic signed [16:0] mul_a, tail;
    logic signed [17:0] mul_b;
    logic signed [34:0] mul_p;

    always_comb
    begin
        case (k_reg)
            3'd0: begin cbase = CB_AW'(0); clen = CB_AW'(CL0); end
            3'd1: begin cbase = CB_AW'(CL0); clen = CB_AW'(CL1); end
            3'd2: begin cbase = CB_AW'(CL0+CL1); clen = CB_AW'(CL2); end
            3'd3: begin cbase = CB_AW'(CL0+CL1+CL2); clen = CB_AW'(CL3); end
            3'd4: begin cbase = CB_AW'(CL0+CL1+CL2+CL3); clen = CB_AW'(CL4); end
            3'd5: begin cbase = CB_AW'(CL0+CL1+CL2+CL3+CL4); clen = CB_AW'(CL5); end
            3'd6: begin cbase = CB_AW'(CL0+CL1+CL2+CL3+CL4+CL5); clen = CB_AW'(CL6); end
            default: begin cbase = CB_AW'(CL0+CL1+CL2+CL3+CL4+CL5+CL6); clen = CB_AW'(CL7); end
        endcase
        case (k_reg[1:0])
            2'd0: begin abase = AP_AW'(0); alen = AP_AW'(AL0); end
            2'd1: begin abase = AP_AW'(AL0); alen = AP_AW'(AL1); end
            2'd2: begin abase = AP_AW'(AL0+AL1); alen = AP_AW'(AL2); end
            default: begin abase = AP_AW'(AL0+AL1+AL2); alen = AP_AW'(AL3); end
        endcase
        gain = k_reg[2] ? gains_high[16*k_reg[1:0] +: 16] : gains_low[16*k_reg[1:0] +: 16];
        pd_d = (int'(predelay) > MAX_PREDELAY) ? PD_AW'(MAX_PREDELAY) : PD_AW'(predelay);
        pd_rd = (ppos_reg >= pd_d) ? ppos_reg - pd_d : ppos_reg + PD_AW'(PD_DEPTH) - pd_d;
        crd = (cpos_reg[k_reg] + 1'b1 == clen) ? '0 : cpos_reg[k_reg] + 1'b1;
        ard = (apos_reg[k_reg[1:0]] + 1'b1 == alen) ? '0 : apos_reg[k_reg[1:0]] + 1'b1;
        diff = 17'(rd_reg) - 17'(lp_reg[k_reg]);
        lp_new = 40'(lp_reg[k_reg]) + ((prod_reg + 40'sd32768) >>> 16);
        ap_x = (40'(v_reg) * 2 + 40'(rd_reg) + 40'sd1) >>> 1;
        ap_y = (40'(rd_reg) * 2 - 40'(v_reg) + 40'sd1) >>> 1;
    end

    // shared multiplier operand select
    always_comb
    begin
        tail = 17'((sum_reg + 19'sd4) >>> 3);
        case (state_reg)
            ST_CB_WAIT:
            begin
                mul_a = diff;
                mul_b = $signed({2'b00, damping});
            end
            ST_CB_MUL1:
            begin
                mul_a = 17'(sat16(lp_new));
                mul_b = $signed({2'b00, gain});
            end
            ST_MIX1:
            begin
                mul_a = 17'(x_reg);
                mul_b = $signed({1'b0, 17'h10000 - 17'(wet)});
            end
            ST_MIX2:
            begin
                mul_a = tail;
                mul_b = $signed({2'b00, wet});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:   if (clr_reg == CLR_W'(CLR_N - 1)) state_next = ST_IDLE;
            ST_IDLE:    if (in_s.valid) state_next = ST_PD_RD;
            ST_PD_RD:   state_next = ST_PD_WAIT;
            ST_PD_WAIT: state_next = ST_AP_RD;
            ST_AP_RD:   state_next = ST_AP_WAIT;
            ST_AP_WAIT: state_next = ST_AP_CALC;
            ST_AP_CALC: state_next = (k_reg == 3'd3) ? ST_CB_RD : ST_AP_RD;
            ST_CB_RD:   state_next = ST_CB_WAIT;
            ST_CB_WAIT: state_next = ST_CB_MUL1;
            ST_CB_MUL1: state_next = ST_CB_MUL2;
            ST_CB_MUL2: state_next = ST_CB_WR;
            ST_CB_WR:   state_next = (k_reg == 3'd7) ? ST_MIX1 : ST_CB_RD;
            ST_MIX1:    state_next = ST_MIX2;
            ST_MIX2:    state_next = ST_MIX3;
            ST_MIX3:    state_next = ST_OUT;
            ST_OUT:     if (out_s.ready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_s.ready   = (state_reg == ST_IDLE);
        out_s.valid  = (state_reg == ST_OUT);
        out_s.sample = y_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            k_reg     <= '0;
            ppos_reg  <= '0;
            for (int i = 0; i < 8; i++)
            begin
                cpos_reg[i] <= '0;
                lp_reg[i]   <= '0;
            end
            for (int i = 0; i < 4; i++)
                apos_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == ST_PD_RD)
                ppos_reg <= (ppos_reg == PD_AW'(PD_DEPTH - 1)) ? '0 : ppos_reg + 1'b1;
            if (state_reg == ST_PD_WAIT)
                k_reg <= '0;
            if (state_reg == ST_AP_CALC)
            begin
                apos_reg[k_reg[1:0]] <= ard;
                k_reg <= (k_reg == 3'd3) ? 3'd0 : k_reg + 1'b1;
            end
            if (state_reg == ST_CB_MUL1)
                lp_reg[k_reg] <= sat16(lp_new);
            if (state_reg == ST_CB_WR)
            begin
                cpos_reg[k_reg] <= crd;
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // datapath and shared multiplier
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                x_reg   <= in_s.sample;
                sum_reg <= '0;
            end
            ST_PD_WAIT: v_reg <= rd_reg;
            ST_AP_CALC: v_reg <= sat16(ap_y);
            ST_CB_RD:   if (k_reg == 3'd0) v_reg <= 16'((40'(v_reg) + 40'sd1) >>> 1);
            ST_CB_WAIT:
            begin
                prod_reg <= 40'(mul_p);
                sum_reg  <= sum_reg + 19'(rd_reg);
            end
            ST_CB_MUL1: prod_reg <= 40'(mul_p);
            ST_CB_MUL2: acc_reg <= 40'(v_reg) + ((prod_reg + 40'sd32768) >>> 16);
            ST_MIX1:    prod_reg <= 40'(mul_p);
            ST_MIX2:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= 40'(mul_p);
            end
            ST_MIX3: y_reg <= sat16((acc_reg + prod_reg + 40'sd32768) >>> 16);
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            if (clr_reg < CLR_W'(CB_DEPTH))
                cb_mem[clr_reg[CB_AW-1:0]] <= '0;
            if (clr_reg < CLR_W'(AP_DEPTH))
                ap_mem[clr_reg[AP_AW-1:0]] <= '0;
            if (clr_reg < CLR_W'(PD_DEPTH))
                pd_mem[clr_reg[PD_AW-1:0]] <= '0;
        end
        if (state_reg == ST_IDLE && in_s.valid)
            pd_mem[ppos_reg] <= in_s.sample;
        if (state_reg == ST_PD_RD)
            rd_reg <= pd_mem[pd_rd];
        if (state_reg == ST_AP_RD)
            rd_reg <= ap_mem[abase + ard];
        if (state_reg == ST_AP_CALC)
            ap_mem[abase + apos_reg[k_reg[1:0]]] <= sat16(ap_x);
        if (state_reg == ST_CB_RD)
            rd_reg <= cb_mem[cbase + crd];
        if (state_reg == ST_CB_WR)
            cb_mem[cbase + cpos_reg[k_reg]] <= sat16(acc_reg);
    end

    a_out_only_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_s.valid |-> !in_s.ready) else $error("output and input open together");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_s.valid && !out_s.ready |=> out_s.valid && $stable(out_s.sample))
        else $error("result dropped");
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !in_s.ready) else $error("request taken during clear");
endmodule

@@ sv/schroeder_reverb.sv @@
// Schroeder reverb: one Q1.15 sample request in, one mixed sample out. Each
// sample runs through the shared multiply/accumulate sequencer: accept, a
// pre-delay read and wait, four allpass steps (read, wait, compute), eight comb
// steps (read, wait, damping and gain multiplies, write), the wet/dry mix and
// a state that presents the result until the sink takes it; no new sample is
// taken before then. After reset a clearing pass zeroes the delay memories, one
// entry a cycle for the longest memory; no sample is taken meanwhile.
module schroeder_reverb #(
    parameter int SAMPLE_RATE_HZ = srev_pkg::SAMPLE_RATE_HZ_DEF,
    parameter int MAX_PREDELAY   = srev_pkg::MAX_PREDELAY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    srev_stream_if.sink                 in_s,
    srev_stream_if.source               out_s,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [srev_pkg::ADDR_W-1:0] paddr,
    input  logic [srev_pkg::DATA_W-1:0] pwdata,
    output logic [srev_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import srev_pkg::*;

    logic [63:0] gains_low, gains_high;
    logic [15:0] damping, wet;
    logic [13:0] predelay;

    srev_regs u_regs (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .gains_low, .gains_high, .damping, .wet, .predelay
    );

    srev_core #(
        .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ),
        .MAX_PREDELAY(MAX_PREDELAY)
    ) u_core (
        .clk, .rst_n, .in_s, .out_s,
        .gains_low, .gains_high, .damping, .wet, .predelay
    );
endmodule

@@ bench/tb_schroeder_reverb.sv @@
module tb_schroeder_reverb;
    timeunit 1ns;
    timeprecision 1ps;

    import srev_pkg::*;

    localparam int COMB_LEN [8] = '{1201, 1297, 1393, 1489, 1777, 1969, 2065, 2257};
    localparam int AP_LEN [4]   = '{241, 337, 529, 625};
    localparam int PD_DEPTH     = MAX_PREDELAY_DEF + 1;
    localparam int REG_STRIDE   = 8;
    localparam int REG_UNUSED_FIRST = REG_PREDELAY + 1;
    localparam int REG_UNUSED_LAST  = (1 << ADDR_W) / REG_STRIDE - 1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    srev_stream_if in_if ();
    srev_stream_if out_if ();

    schroeder_reverb dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_s    (in_if),
        .out_s   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [63:0] gains_low_q, gains_high_q;
    logic [15:0] damping_q, wet_q;
    logic [13:0] predelay_q;
    logic signed [15:0] comb_mem [8][2257];
    logic signed [15:0] comb_lp [8];
    int comb_pos [8];
    logic signed [15:0] ap_mem [4][625];
    int ap_pos [4];
    logic signed [15:0] pd_mem [PD_DEPTH];
    int pd_pos;

    logic signed [15:0] expected_samples [$];
    int sender_idle_pct;
    int receiver_stall_pct;
    int holdoff_cycles;
    int samples_sent;
    int samples_checked;
    int mismatches;

    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [15:0] clip_q15(input longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return 16'(v);
    endfunction

    function automatic logic signed [15:0] reverb_predict(input logic signed [15:0] x);
        int dly;
        int rd;
        longint v, dl, lp, g, sum, tail, y;
        logic [63:0] gains;
        dly = (predelay_q > MAX_PREDELAY_DEF) ? MAX_PREDELAY_DEF : int'(predelay_q);
        pd_mem[pd_pos] = x;
        rd = (pd_pos + PD_DEPTH - dly) % PD_DEPTH;
        v = pd_mem[rd];
        pd_pos = (pd_pos + 1) % PD_DEPTH;
        for (int k = 0; k < 4; k++)
        begin
            rd = (ap_pos[k] + 1) % AP_LEN[k];
            dl = ap_mem[k][rd];
            ap_mem[k][ap_pos[k]] = clip_q15(round_shift(2 * v + dl, 1));
            v = clip_q15(round_shift(2 * dl - v, 1));
            ap_pos[k] = (ap_pos[k] + 1) % AP_LEN[k];
        end
        v = round_shift(v, 1);
        sum = 0;
        for (int k = 0; k < 8; k++)
        begin
            gains = (k < 4) ? gains_low_q : gains_high_q;
            g = longint'((gains >> (16 * (k % 4))) & 64'hFFFF);
            rd = (comb_pos[k] + 1) % COMB_LEN[k];
            dl = comb_mem[k][rd];
            lp = comb_lp[k];
            lp = lp + round_shift(longint'(damping_q) * (dl - lp), 16);
            comb_lp[k] = clip_q15(lp);
            comb_mem[k][comb_pos[k]] = clip_q15(v + round_shift(lp * g, 16));
            comb_pos[k] = (comb_pos[k] + 1) % COMB_LEN[k];
            sum += dl;
        end
        tail = round_shift(sum, 3);
        y = round_shift(longint'(x) * (65536 - longint'(wet_q)) + tail * longint'(wet_q), 16);
        return clip_q15(y);
    endfunction

    // receiver: random stalls plus long hold-off
    initial out_if.ready = 1'b0;
    always @(posedge clk)
    begin
        if (holdoff_cycles > 0)
        begin
            holdoff_cycles <= holdoff_cycles - 1;
            out_if.ready <= 1'b0;
        end
        else
            out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("sample_out: unexpected result %0d", out_if.sample);
                mismatches++;
            end
            else
            begin
                if (out_if.sample !== expected_samples[0])
                begin
                    $error("sample_out: expected %0d, got %0d",
                           expected_samples[0], out_if.sample);
                    mismatches++;
                end
                void'(expected_samples.pop_front());
                samples_checked++;
            end
        end
    end

    task automatic reg_write(input int idx, input logic [63:0] value);
        paddr <= ADDR_W'(idx * REG_STRIDE);
        pwdata <= value;
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_GAINS_LOW:  gains_low_q = value;
            REG_GAINS_HIGH: gains_high_q = value;
            REG_DAMPING:    damping_q = value[15:0];
            REG_WET:        wet_q = value[15:0];
            REG_PREDELAY:   predelay_q = value[13:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_sample(input logic signed [15:0] s);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct && gap < 20)
            gap++;
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.sample <= s;
        do @(posedge clk); while (!in_if.ready);
        expected_samples.push_back(reverb_predict(s));
        samples_sent++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic signed [15:0] random_sample();
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(15)) - 16'sd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_sample(random_sample());
    endtask

    task automatic test_reset_settings();
        logic signed [15:0] directed [12];
        directed = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001, 16'shffff, 16'sh5555,
                     16'shaaaa, 16'sh4000, 16'shc000, 16'sh7fff, 16'sh7fff, 16'sh8000};
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        foreach (directed[i])
            send_sample(directed[i]);
        send_random(200);
        drain();
    endtask

    task automatic test_full_scale();
        sender_idle_pct = 48;
        receiver_stall_pct = 0;
        reg_write(REG_GAINS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(REG_GAINS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(REG_DAMPING, 64'h0000_0000_0000_FFFF);
        reg_write(REG_WET, 64'h0000_0000_0000_FFFF);
        reg_write(REG_PREDELAY, 64'd0);
        // unmapped addresses must not disturb anything
        for (int i = REG_UNUSED_FIRST; i <= REG_UNUSED_LAST; i++)
            reg_write(i, 64'($urandom) << 32 | 64'($urandom));
        repeat (4) send_sample(16'sh7fff);
        repeat (4) send_sample(16'sh8000);
        send_random(250);
        drain();
    endtask

    task automatic test_dry_only();
        sender_idle_pct = 0;
        receiver_stall_pct = 48;
        reg_write(REG_GAINS_LOW, 64'd0);
        reg_write(REG_GAINS_HIGH, 64'd0);
        reg_write(REG_DAMPING, 64'd0);
        reg_write(REG_WET, 64'd0);
        reg_write(REG_PREDELAY, 64'(MAX_PREDELAY_DEF));
        send_random(200);
        drain();
    endtask

    task automatic test_wide_values();
        sender_idle_pct = 9;
        receiver_stall_pct = 9;
        // predelay beyond the maximum is clamped, upper bits are dropped
        reg_write(REG_PREDELAY, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(REG_DAMPING, 64'hABCD_0000_1234_C000);
        reg_write(REG_WET, 64'h5A5A_0000_0001_8000);
        reg_write(REG_GAINS_LOW, 64'hF000_E000_D000_C000);
        reg_write(REG_GAINS_HIGH, 64'hFFFF_8000_4000_0001);
        send_random(200);
        drain();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = (phase % 2) ? 48 : 9;
            receiver_stall_pct = (phase > 1) ? 48 : 0;
            reg_write(REG_GAINS_LOW, {$urandom, $urandom});
            reg_write(REG_GAINS_HIGH, {$urandom, $urandom});
            reg_write(REG_DAMPING, 64'($urandom));
            reg_write(REG_WET, 64'($urandom));
            reg_write(REG_PREDELAY, 64'($urandom_range(phase == 3 ? 16383 : 300)));
            send_random(160);
            drain();
        end
    endtask

    task automatic test_backpressure();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        holdoff_cycles = 600;
        send_random(40);
        drain();
        send_random(20);
        drain();
    endtask

    initial
    begin
        gains_low_q = '0;
        gains_high_q = '0;
        damping_q = DAMPING_RST;
        wet_q = WET_RST;
        predelay_q = PREDELAY_RST;
        foreach (comb_mem[k, i])
            comb_mem[k][i] = '0;
        foreach (ap_mem[k, i])
            ap_mem[k][i] = '0;
        foreach (pd_mem[i])
            pd_mem[i] = '0;
        foreach (comb_lp[k])
        begin
            comb_lp[k] = '0;
            comb_pos[k] = 0;
        end
        foreach (ap_pos[k])
            ap_pos[k] = 0;
        pd_pos = 0;
        holdoff_cycles = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        samples_sent = 0;
        samples_checked = 0;
        mismatches = 0;
        in_if.valid = 1'b0;
        in_if.sample = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_settings();
        test_full_scale();
        test_dry_only();
        test_wide_values();
        test_random_settings();
        test_backpressure();
        $display("covered reset, full-scale, dry-only, clamped and random settings with stalls");
        $display("%0d samples sent, %0d results checked, %0d mismatches",
                 samples_sent, samples_checked, mismatches);
        if (mismatches == 0)
            $display("[schroeder_reverb] OK");
        else
            $display("[schroeder_reverb] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[schroeder_reverb] ERROR");
        $finish;
    end

endmodule

@@ schroeder_reverb.f @@
sv/srev_pkg.sv
sv/srev_stream_if.sv
sv/srev_regs.sv
sv/srev_core.sv
sv/schroeder_reverb.sv
bench/tb_schroeder_reverb.sv
